@@ rtl/core/rvf_pkg.sv @@
package rvf_pkg;

  localparam int H_W            = 16;
  localparam int ROW_LEN_W      = 13;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int MAX_RUN        = 63;
  localparam int MAX_ROW_LENGTH = 4096;
  localparam int Q_DEPTH        = 4;

  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam int OFF_W  = H_W + 1;
  localparam int PROD_W = H_W + RUN_W;
  localparam int STEP_W = $clog2(PROD_W);

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOID_THRESHOLD = 1'b1;

  localparam logic [ROW_LEN_W-1:0]    ROW_LENGTH_RST     = 13'd1201;
  localparam logic signed [H_W-1:0]   VOID_THRESHOLD_RST = -16'sd30000;

  typedef struct packed {
    logic [RUN_W-1:0]         fill_cnt;
    logic                     interp;
    logic signed [H_W-1:0]    base;
    logic                     has_good;
    logic signed [H_W-1:0]    good_val;
  } rvf_job_t;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [PROD_W-1:0]  mag;
    logic [RUN_W:0]     divisor;
  } rvf_div_req_t;

  typedef struct packed {
    logic                    valid;
    logic signed [OFF_W-1:0] quot;
  } rvf_div_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FLUSH,
    BK_DIV,
    BK_WAIT,
    BK_GOOD
  } rvf_back_e;

endpackage

@@ rtl/core/rvf_intf.sv @@
interface rvf_in_if;
  logic                         valid;
  logic                         ready;
  logic [rvf_pkg::H_W-1:0]      raw_word;

  modport source (output valid, output raw_word, input ready);
  modport sink (input valid, input raw_word, output ready);
endinterface

interface rvf_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [rvf_pkg::H_W-1:0] height;
  logic                         was_filled;
  logic                         run_flushed;
  logic                         last;

  modport source (output valid, output height, output was_filled, output run_flushed,
                  output last, input ready);
  modport sink (input valid, input height, input was_filled, input run_flushed,
                input last, output ready);
endinterface

@@ rtl/core/rvf_front.sv @@
module rvf_front #(
  parameter int MaxRowLength = rvf_pkg::MAX_ROW_LENGTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rvf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rvf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  rvf_in_if.sink                          in_i,
  input  logic                            full_i,
  output logic                            push_o,
  output rvf_pkg::rvf_job_t               job_o
);

  localparam int CW = $clog2(MaxRowLength);
  localparam int LW = (CW + 1 > rvf_pkg::ROW_LEN_W) ? CW + 1 : rvf_pkg::ROW_LEN_W;

  logic [rvf_pkg::ROW_LEN_W-1:0]   row_len_q;
  logic signed [rvf_pkg::H_W-1:0]  thr_q;
  logic signed [rvf_pkg::H_W-1:0]  left_q, left_d;
  logic                            lvalid_q, lvalid_d;
  logic [rvf_pkg::RUN_W-1:0]       run_q, run_d;
  logic [CW-1:0]                   col_q, col_d;

  logic                            accept;
  logic signed [rvf_pkg::H_W-1:0]  h;
  logic                            is_void;
  logic [rvf_pkg::RUN_W-1:0]       run_inc;
  logic [LW-1:0]                   row_ext, len_c, col_nxt;
  logic                            row_end;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    row_ext = LW'(row_len_q);
    priority if (row_ext < LW'(2)) begin
      len_c = LW'(2);
    end else if (row_ext > LW'(MaxRowLength)) begin
      len_c = LW'(MaxRowLength);
    end else begin
      len_c = row_ext;
    end
  end

  always_comb begin
    h       = {in_i.raw_word[7:0], in_i.raw_word[15:8]};
    is_void = h < thr_q;
    run_inc = run_q + 1'b1;
    col_nxt = LW'(col_q) + LW'(1);
    row_end = col_nxt >= len_c;

    job_o    = '0;
    push_o   = 1'b0;
    run_d    = run_q;
    left_d   = left_q;
    lvalid_d = lvalid_q;
    col_d    = col_q;

    if (accept) begin
      if (is_void) begin
        job_o.fill_cnt = run_inc;
        job_o.base     = left_q;
        if (run_inc >= rvf_pkg::RUN_W'(rvf_pkg::MAX_RUN) || row_end) begin
          push_o = 1'b1;
          run_d  = '0;
        end else begin
          run_d = run_inc;
        end
      end else begin
        job_o.fill_cnt = run_q;
        job_o.interp   = lvalid_q && (run_q != '0);
        job_o.base     = lvalid_q ? left_q : h;
        job_o.has_good = 1'b1;
        job_o.good_val = h;
        push_o         = 1'b1;
        run_d          = '0;
        left_d         = h;
        lvalid_d       = 1'b1;
      end
      if (row_end) begin
        col_d    = '0;
        left_d   = '0;
        lvalid_d = 1'b0;
        run_d    = '0;
      end else begin
        col_d = col_nxt[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= rvf_pkg::ROW_LENGTH_RST;
      thr_q     <= rvf_pkg::VOID_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rvf_pkg::CFG_ROW_LENGTH:     row_len_q <= cfg_wdata_i[rvf_pkg::ROW_LEN_W-1:0];
        rvf_pkg::CFG_VOID_THRESHOLD: thr_q     <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      lvalid_q <= 1'b0;
      run_q    <= '0;
      col_q    <= '0;
    end else begin
      left_q   <= left_d;
      lvalid_q <= lvalid_d;
      run_q    <= run_d;
      col_q    <= col_d;
    end
  end

  // A run is always flushed once it reaches its limit, so the count never sits there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   run_q < rvf_pkg::RUN_W'(rvf_pkg::MAX_RUN))
    else $error("void run count reached its limit without a flush");

endmodule

@@ rtl/core/rvf_queue.sv @@
module rvf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rvf_pkg::rvf_job_t  job_i,
  input  logic               pop_i,
  output rvf_pkg::rvf_job_t  job_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int PTR_W = $clog2(rvf_pkg::Q_DEPTH);

  rvf_pkg::rvf_job_t  slot_q [rvf_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [PTR_W:0]     cnt_q;

  assign full_o  = cnt_q == (PTR_W + 1)'(rvf_pkg::Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(rvf_pkg::Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(rvf_pkg::Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PTR_W + 1)'(push_i) - (PTR_W + 1)'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(push_i && full_o) && !(pop_i && empty_o))
    else $error("job queue overrun or underrun");

endmodule

@@ rtl/core/rvf_divider.sv @@
module rvf_divider (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rvf_pkg::rvf_div_req_t  req_i,
  output rvf_pkg::rvf_div_rsp_t  rsp_o
);

  logic                          busy_q, done_q, neg_q;
  logic [rvf_pkg::STEP_W-1:0]    step_q;
  logic [rvf_pkg::RUN_W:0]       div_q, rem_q, rem_d;
  logic [rvf_pkg::PROD_W-1:0]    quo_q, quo_d;
  logic [rvf_pkg::RUN_W+1:0]     trial, diff;
  logic                          ge;
  logic signed [rvf_pkg::OFF_W-1:0] mag17;

  always_comb begin
    trial = {rem_q, quo_q[rvf_pkg::PROD_W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? diff[rvf_pkg::RUN_W:0] : trial[rvf_pkg::RUN_W:0];
    quo_d = {quo_q[rvf_pkg::PROD_W-2:0], ge};
    mag17 = {1'b0, quo_q[rvf_pkg::H_W-1:0]};
  end

  assign rsp_o.valid = done_q;
  assign rsp_o.quot  = neg_q ? -mag17 : mag17;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= rvf_pkg::STEP_W'(rvf_pkg::PROD_W - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.mag;
      rem_q <= '0;
      div_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   req_i.start |=> busy_q && !done_q)
    else $error("divider did not start on request");

endmodule

@@ rtl/core/rvf_back.sv @@
module rvf_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rvf_pkg::rvf_job_t      job_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output rvf_pkg::rvf_div_req_t  div_req_o,
  input  rvf_pkg::rvf_div_rsp_t  div_rsp_i,
  rvf_out_if.source              out_o
);

  localparam int PS_W = rvf_pkg::OFF_W + rvf_pkg::RUN_W;

  rvf_pkg::rvf_back_e                state_q, state_d;
  rvf_pkg::rvf_job_t                 job_q;
  logic [rvf_pkg::RUN_W-1:0]         k_q, k_inc;
  logic signed [rvf_pkg::OFF_W-1:0]  off_q, off_new;
  logic signed [PS_W-1:0]            prod_q, prod_abs;

  logic                              out_valid_q;
  logic signed [rvf_pkg::H_W-1:0]    height_q, emit_height;
  logic                              filled_q, flushed_q, last_q;
  logic                              emit_filled, emit_flushed, emit_last;
  logic                              can_emit, fill_done, emit;
  logic signed [rvf_pkg::OFF_W-1:0]  interp_sum;

  assign can_emit  = !out_valid_q || out_o.ready;
  assign k_inc     = k_q + 1'b1;
  assign fill_done = k_inc == job_q.fill_cnt;
  assign off_new   = {job_i.good_val[rvf_pkg::H_W-1], job_i.good_val}
                   - {job_i.base[rvf_pkg::H_W-1], job_i.base};
  assign prod_abs  = prod_q[PS_W-1] ? -prod_q : prod_q;
  assign interp_sum = {job_q.base[rvf_pkg::H_W-1], job_q.base} + div_rsp_i.quot;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rvf_pkg::BK_IDLE: begin
        if (!empty_i) begin
          if (job_i.fill_cnt == '0) begin
            state_d = rvf_pkg::BK_GOOD;
          end else if (job_i.interp) begin
            state_d = rvf_pkg::BK_DIV;
          end else begin
            state_d = rvf_pkg::BK_FLUSH;
          end
        end
      end
      rvf_pkg::BK_FLUSH: begin
        if (can_emit && fill_done) begin
          state_d = job_q.has_good ? rvf_pkg::BK_GOOD : rvf_pkg::BK_IDLE;
        end
      end
      rvf_pkg::BK_DIV: begin
        state_d = rvf_pkg::BK_WAIT;
      end
      rvf_pkg::BK_WAIT: begin
        if (div_rsp_i.valid && can_emit) begin
          state_d = fill_done ? rvf_pkg::BK_GOOD : rvf_pkg::BK_DIV;
        end
      end
      rvf_pkg::BK_GOOD: begin
        if (can_emit) begin
          state_d = rvf_pkg::BK_IDLE;
        end
      end
      default: state_d = rvf_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o             = 1'b0;
    emit              = 1'b0;
    emit_height       = job_q.base;
    emit_filled       = 1'b0;
    emit_flushed      = 1'b0;
    emit_last         = 1'b0;
    div_req_o.start   = 1'b0;
    div_req_o.neg     = prod_q[PS_W-1];
    div_req_o.mag     = prod_abs[rvf_pkg::PROD_W-1:0];
    div_req_o.divisor = {1'b0, job_q.fill_cnt} + 1'b1;
    unique case (state_q)
      rvf_pkg::BK_IDLE: begin
        pop_o = !empty_i;
      end
      rvf_pkg::BK_FLUSH: begin
        emit         = can_emit;
        emit_filled  = 1'b1;
        emit_flushed = 1'b1;
        emit_last    = fill_done && !job_q.has_good;
      end
      rvf_pkg::BK_DIV: begin
        div_req_o.start = 1'b1;
      end
      rvf_pkg::BK_WAIT: begin
        emit        = div_rsp_i.valid && can_emit;
        emit_height = interp_sum[rvf_pkg::H_W-1:0];
        emit_filled = 1'b1;
      end
      rvf_pkg::BK_GOOD: begin
        emit        = can_emit;
        emit_height = job_q.good_val;
        emit_last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rvf_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q  <= job_i;
      off_q  <= off_new;
      prod_q <= PS_W'(off_new);
      k_q    <= '0;
    end else if (emit && state_q != rvf_pkg::BK_GOOD) begin
      k_q    <= k_inc;
      prod_q <= prod_q + PS_W'(off_q);
    end
    if (emit) begin
      height_q  <= emit_height;
      filled_q  <= emit_filled;
      flushed_q <= emit_flushed;
      last_q    <= emit_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.height      = height_q;
  assign out_o.was_filled  = filled_q;
  assign out_o.run_flushed = flushed_q;
  assign out_o.last        = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == rvf_pkg::BK_WAIT |-> job_q.interp && job_q.fill_cnt != '0)
    else $error("division wait entered for a job without interpolation");

endmodule

@@ rtl/core/row_void_fill_interpolator.sv @@
// Row void-fill interpolator: takes byte-swapped elevation words, one per
// sample in row order, and delivers corrected signed heights in the same
// order, with voids replaced by linear interpolation between their good
// neighbors or, at a row edge or after an over-long run, by the nearest good
// value. A front stage classifies each word and tracks the row state; a
// four-entry job queue lets it run ahead of the back stage, which produces
// the results. Each interpolated void waits on the restoring divider, which
// resolves one quotient bit per cycle over the 22-bit product of offset and
// position.
module row_void_fill_interpolator #(
  parameter int MaxRowLength = rvf_pkg::MAX_ROW_LENGTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rvf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rvf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  rvf_in_if.sink                          in_i,
  rvf_out_if.source                       out_o
);

  rvf_pkg::rvf_job_t      push_job, head_job;
  logic                   push, pop, full, empty;
  rvf_pkg::rvf_div_req_t  div_req;
  rvf_pkg::rvf_div_rsp_t  div_rsp;

  rvf_front #(
    .MaxRowLength (MaxRowLength)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  rvf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (full),
    .empty_o (empty)
  );

  rvf_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rvf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (head_job),
    .empty_i   (empty),
    .pop_o     (pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .out_o     (out_o)
  );

endmodule

@@ tb/rvf_fill_checker.sv @@
module rvf_fill_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rvf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rvf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  rvf_in_if                              word_in_i,
  rvf_out_if                             word_out_i,
  output int                             mismatch_count_o,
  output int                             awaited_count_o
);

  typedef struct {
    logic signed [rvf_pkg::H_W-1:0] height;
    logic                           was_filled;
    logic                           run_flushed;
    logic                           last;
  } fill_word_t;

  fill_word_t                     expected_words[$];
  logic [rvf_pkg::ROW_LEN_W-1:0]  row_len_q = rvf_pkg::ROW_LENGTH_RST;
  logic signed [rvf_pkg::H_W-1:0] thr_q     = rvf_pkg::VOID_THRESHOLD_RST;
  logic signed [rvf_pkg::H_W-1:0] left_q    = '0;
  bit                             left_ok   = 1'b0;
  int                             run_q     = 0;
  int                             col_q     = 0;

  function automatic fill_word_t fill_word(input logic signed [rvf_pkg::H_W-1:0] h,
                                           input logic f, input logic fl);
    fill_word_t w;
    w.height      = h;
    w.was_filled  = f;
    w.run_flushed = fl;
    w.last        = 1'b0;
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count_o++;
  endtask

  task automatic queue_word(input fill_word_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic predict_fill(input logic [rvf_pkg::H_W-1:0] raw);
    logic signed [rvf_pkg::H_W-1:0] h;
    logic signed [rvf_pkg::H_W-1:0] left;
    int                             len;
    int                             off;
    int                             first;
    h     = {raw[7:0], raw[15:8]};
    left  = left_ok ? left_q : '0;
    len   = int'(row_len_q);
    first = expected_words.size();
    if (len < 2) len = 2;
    if (len > rvf_pkg::MAX_ROW_LENGTH) len = rvf_pkg::MAX_ROW_LENGTH;

    if (h < thr_q) begin
      run_q++;
      if (run_q >= rvf_pkg::MAX_RUN) begin
        repeat (run_q) queue_word(fill_word(left, 1'b1, 1'b1));
        run_q = 0;
      end
    end else begin
      if (run_q > 0) begin
        if (left_ok) begin
          off = int'(h) - int'(left);
          for (int k = 1; k <= run_q; k++) begin
            queue_word(fill_word(16'(int'(left) + (off * k) / (run_q + 1)),
                                 1'b1, 1'b0));
          end
        end else begin
          repeat (run_q) queue_word(fill_word(h, 1'b1, 1'b1));
        end
        run_q = 0;
      end
      queue_word(fill_word(h, 1'b0, 1'b0));
      left_q  = h;
      left_ok = 1'b1;
      left    = h;
    end

    col_q++;
    if (col_q >= len) begin
      if (run_q > 0) repeat (run_q) queue_word(fill_word(left, 1'b1, 1'b1));
      col_q   = 0;
      left_ok = 1'b0;
      left_q  = '0;
      run_q   = 0;
    end

    if (expected_words.size() > first) expected_words[$].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fill_word_t want;
    if (!rst_ni) begin
      expected_words.delete();
      mismatch_count_o = 0;
      row_len_q = rvf_pkg::ROW_LENGTH_RST;
      thr_q     = rvf_pkg::VOID_THRESHOLD_RST;
      left_q    = '0;
      left_ok   = 1'b0;
      run_q     = 0;
      col_q     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rvf_pkg::CFG_ROW_LENGTH:     row_len_q = cfg_wdata_i[rvf_pkg::ROW_LEN_W-1:0];
          rvf_pkg::CFG_VOID_THRESHOLD: thr_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (word_in_i.valid && word_in_i.ready) predict_fill(word_in_i.raw_word);
      if (word_out_i.valid && word_out_i.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word, height %0d", word_out_i.height));
        end else begin
          want = expected_words.pop_front();
          if (word_out_i.height !== want.height)
            report_mismatch($sformatf("height %0d, wanted %0d",
                                      word_out_i.height, want.height));
          if (word_out_i.was_filled !== want.was_filled)
            report_mismatch($sformatf("was_filled %b, wanted %b (height %0d)",
                                      word_out_i.was_filled, want.was_filled, want.height));
          if (word_out_i.run_flushed !== want.run_flushed)
            report_mismatch($sformatf("run_flushed %b, wanted %b (height %0d)",
                                      word_out_i.run_flushed, want.run_flushed,
                                      want.height));
          if (word_out_i.last !== want.last)
            report_mismatch($sformatf("last %b, wanted %b (height %0d)",
                                      word_out_i.last, want.last, want.height));
        end
      end
    end
    awaited_count_o = expected_words.size();
  end

endmodule

@@ tb/row_void_fill_interpolator_tb.sv @@
module row_void_fill_interpolator_tb;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [rvf_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [rvf_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  int                             mismatch_count;
  int                             awaited_count;
  int                             send_idle_pct = 0;
  int                             stall_pct = 0;
  int                             cur_thr = -30000;

  rvf_in_if  word_in_if ();
  rvf_out_if word_out_if ();

  row_void_fill_interpolator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (word_in_if),
    .out_o       (word_out_if)
  );

  rvf_fill_checker fill_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .word_in_i        (word_in_if),
    .word_out_i       (word_out_if),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    word_out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [rvf_pkg::H_W-1:0] to_raw(input logic [rvf_pkg::H_W-1:0] h);
    return {h[7:0], h[15:8]};
  endfunction

  task automatic send_word(input logic [rvf_pkg::H_W-1:0] raw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      word_in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    word_in_if.valid    <= 1'b1;
    word_in_if.raw_word <= raw;
    do @(posedge clk_i); while (!word_in_if.ready);
  endtask

  task automatic send_height(input bit want_void);
    int h;
    if (want_void && cur_thr > -32768) begin
      h = -32768 + int'($urandom_range(0, cur_thr + 32767));
    end else begin
      h = cur_thr + int'($urandom_range(0, 32767 - cur_thr));
    end
    send_word(to_raw(16'(h)));
  endtask

  task automatic drain_results(input int hold);
    word_in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (hold) @(posedge clk_i);
  endtask

  task automatic set_config(input int len, input int thr);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= rvf_pkg::CFG_ROW_LENGTH;
    cfg_wdata_i <= 16'(len);
    @(posedge clk_i);
    cfg_idx_i   <= rvf_pkg::CFG_VOID_THRESHOLD;
    cfg_wdata_i <= 16'(thr);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    cur_thr = thr;
  endtask

  task automatic run_phase(input int len, input int thr, input int n_items,
                           input int send_pct, input int stall,
                           input bit long_runs, input bit mid_pause);
    int sent;
    int run;
    bit paused;
    set_config(len, thr);
    send_idle_pct = send_pct;
    stall_pct     = stall;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (mid_pause && !paused && sent >= n_items / 2) begin
        drain_results(0);
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) begin
        send_word(16'($urandom()));
        sent++;
      end else begin
        run = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 3));
        if (long_runs && (sent == 0 || $urandom_range(0, 19) == 0))
          run = int'($urandom_range(60, 66));
        repeat (run) send_height(1'b1);
        send_height(1'b0);
        sent += run + 1;
      end
    end
    drain_results(64);
  endtask

  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= rvf_pkg::CFG_ROW_LENGTH;
    cfg_wdata_i          <= '0;
    word_in_if.valid     <= 1'b0;
    word_in_if.raw_word  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Leading voids, interpolation up to the top and down toward the threshold.
    send_word(to_raw(-16'sd32768));
    send_word(to_raw(-16'sd30001));
    send_word(to_raw(-16'sd30000));
    send_word(to_raw(-16'sd32768));
    send_word(to_raw(-16'sd31000));
    send_word(to_raw(16'sd32767));
    send_word(to_raw(-16'sd1));
    send_word(to_raw(-16'sd32000));
    send_word(to_raw(-16'sd29999));
    send_word(to_raw(16'sd0));
    send_word(to_raw(-16'sd30500));
    send_word(to_raw(-16'sd32768));
    send_word(to_raw(-16'sd30001));
    send_word(to_raw(-16'sd12345));
    drain_results(64);

    // A row length below the minimum, and a threshold that makes nothing void.
    set_config(0, -32768);
    send_word(to_raw(-16'sd32768));
    send_word(to_raw(16'sd32767));
    send_word(16'h5aa5);
    drain_results(64);

    // Almost everything void: rows with no good value, trailing and leading voids.
    set_config(2, 32767);
    send_word(to_raw(-16'sd32768));
    send_word(to_raw(16'sd32766));
    send_word(to_raw(16'sd32767));
    send_word(to_raw(16'sd0));
    send_word(to_raw(-16'sd1));
    send_word(to_raw(16'sd32767));
    drain_results(64);

    run_phase(5, -30000, 30, 0, 0, 1'b0, 1'b0);
    run_phase(4096, 0, 55, 50, 0, 1'b1, 1'b1);
    run_phase(2, int'($urandom_range(0, 2000)) - 1000, 40, 0, 50, 1'b0, 1'b0);
    run_phase(8191, -32768, 30, 27, 27, 1'b0, 1'b0);
    run_phase(3, 32767, 30, 27, 27, 1'b0, 1'b0);
    run_phase(7, -30000, 25, 0, 0, 1'b0, 1'b0);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
